[rtl/core/sdlp_pkg.sv]
// package for the long-press switch debouncer
// holds integrator constants, operation codes and the state and result types
// no dependencies
package sdlp_pkg;

	localparam int INTEG_W = 5;
	localparam int TICKS_W = 16;

	localparam logic [INTEG_W-1:0] INTEG_LOW_EDGE  = 5'd2;
	localparam logic [INTEG_W-1:0] INTEG_HIGH_EDGE = 5'd30;
	localparam logic [INTEG_W-1:0] INTEG_MIN       = 5'd1;
	localparam logic [INTEG_W-1:0] INTEG_MAX       = 5'd31;

	localparam logic [TICKS_W-1:0] LIMIT_RESET = 16'd2000;

	// action codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic [INTEG_W-1:0] integ;
		logic               held;
		logic [TICKS_W-1:0] hold_ticks;
		logic               press_flag;
		logic               release_flag;
	} state_t;

	typedef struct packed {
		logic pressed_event;
		logic released_event;
		logic long_press_event;
		logic held;
	} result_t;

endpackage

[rtl/core/sdlp_if.sv]
// channel interfaces for the long-press switch debouncer
// sample, result and configuration channels, each valid/ready
// no dependencies
interface sdlp_sample_if;
	logic valid;
	logic ready;
	logic action;
	logic raw_level;

	modport source (output valid, output action, output raw_level, input ready);
	modport sink (input valid, input action, input raw_level, output ready);
endinterface

interface sdlp_result_if;
	logic valid;
	logic ready;
	logic pressed_event;
	logic released_event;
	logic long_press_event;
	logic held;

	modport source (output valid, output pressed_event, output released_event,
		output long_press_event, output held, input ready);
	modport sink (input valid, input pressed_event, input released_event,
		input long_press_event, input held, output ready);
endinterface

interface sdlp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] long_press_limit;

	modport source (output valid, output long_press_limit, input ready);
	modport sink (input valid, input long_press_limit, output ready);
endinterface

[rtl/core/sdlp_update.sv]
// next-state and result logic for one beat of the debouncer
// integrator clamp, event latching, long-press counter and read-clear
// depends on sdlp_pkg
module sdlp_update
	import sdlp_pkg::*;
(
	input  state_t             state_cur,
	input  logic               action,
	input  logic               raw_level,
	input  logic [TICKS_W-1:0] limit,
	output state_t             state_nxt,
	output result_t            result
);

	logic signed [INTEG_W+1:0] step;
	logic [TICKS_W:0]          ticks_inc;
	state_t                    tick_st;
	logic                      longp_cur;

	always_comb begin
		tick_st = state_cur;
		step = $signed({2'b00, state_cur.integ}) +
			(raw_level ? (INTEG_W+2)'(1) : -(INTEG_W+2)'(1));
		if (step < $signed({2'b00, INTEG_LOW_EDGE})) begin
			if (state_cur.integ == INTEG_LOW_EDGE) begin
				tick_st.press_flag = 1'b1;
			end
			tick_st.integ = INTEG_MIN;
			tick_st.held = 1'b1;
		end else if (step > $signed({2'b00, INTEG_HIGH_EDGE})) begin
			if (state_cur.integ == INTEG_HIGH_EDGE) begin
				tick_st.release_flag = 1'b1;
			end
			tick_st.integ = INTEG_MAX;
			tick_st.held = 1'b0;
		end else begin
			tick_st.integ = step[INTEG_W-1:0];
		end

		// counter saturates at the limit, even if the limit was lowered
		ticks_inc = {1'b0, state_cur.hold_ticks} + (TICKS_W+1)'(1);
		if (!tick_st.held) begin
			tick_st.hold_ticks = '0;
		end else if (ticks_inc >= {1'b0, limit}) begin
			tick_st.hold_ticks = limit;
		end else begin
			tick_st.hold_ticks = ticks_inc[TICKS_W-1:0];
		end
	end

	assign longp_cur = (state_cur.hold_ticks >= limit);

	always_comb begin
		state_nxt = state_cur;
		result = '0;
		unique case (action)
			ACT_TICK: begin
				state_nxt = tick_st;
				result.pressed_event = tick_st.press_flag;
				result.released_event = tick_st.release_flag;
				result.long_press_event = (tick_st.hold_ticks >= limit);
				result.held = tick_st.held;
			end
			ACT_READ: begin
				result.pressed_event = state_cur.press_flag;
				result.released_event = state_cur.release_flag;
				result.long_press_event = longp_cur;
				result.held = state_cur.held;
				state_nxt.press_flag = 1'b0;
				state_nxt.release_flag = 1'b0;
				if (longp_cur) begin
					state_nxt.hold_ticks = '0;
				end
			end
			default: begin
				state_nxt = state_cur;
			end
		endcase
	end

endmodule

[rtl/core/switch_debouncer_long_press.sv]
// Integrating debouncer for an active-low switch with press, release and long-press
// events. Each sample beat is either a tick carrying the raw pin level or a read that
// returns the sticky flags and clears them. A beat is taken every cycle unless input
// ready is low; its result passes through the input register, then the result register,
// and the whole state update is combinational between them. Input ready drops only while
// the input register is full and the result register holds a beat not yet taken.
// The long-press limit is written over the configuration channel, which is always
// ready; it resets to 2000 ticks.
module switch_debouncer_long_press
	import sdlp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sdlp_sample_if.sink   sample_ch,
	sdlp_result_if.source result_ch,
	sdlp_cfg_if.sink      cfg_ch
);

	logic               valid_s1;
	logic               action_s1;
	logic               raw_level_s1;
	logic               valid_s2;
	result_t            result_s2;
	state_t             state_q;
	logic [TICKS_W-1:0] limit_q;

	state_t             state_d;
	result_t            result_d;
	logic               advance;

	assign advance = valid_s1 && (!valid_s2 || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;
	assign cfg_ch.ready = 1'b1;

	sdlp_update u_update (
		.state_cur (state_q),
		.action    (action_s1),
		.raw_level (raw_level_s1),
		.limit     (limit_q),
		.state_nxt (state_d),
		.result    (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q <= state_d;
			end else if (result_ch.ready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_ch.valid) begin
				limit_q <= cfg_ch.long_press_limit;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			action_s1 <= sample_ch.action;
			raw_level_s1 <= sample_ch.raw_level;
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign result_ch.valid = valid_s2;
	assign result_ch.pressed_event = result_s2.pressed_event;
	assign result_ch.released_event = result_s2.released_event;
	assign result_ch.long_press_event = result_s2.long_press_event;
	assign result_ch.held = result_s2.held;

endmodule

[rtl/core/sdlp_checker.sv]
// port-level checks for the long-press switch debouncer
// bound to switch_debouncer_long_press; sees only its channel ports
// no package dependencies
module sdlp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_ready
);

	// a waiting result beat is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a new result only follows an earlier taken sample beat
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result beat without a sample beat");

	// input back-pressure only while the result side is stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("sample ready low with no stalled result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind switch_debouncer_long_press sdlp_checker u_sdlp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_ch.valid),
	.in_ready  (sample_ch.ready),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.cfg_ready (cfg_ch.ready)
);
